// ===== sv/ptzf_pkg.sv =====
// Shared types, byte codes and speed scaling helpers for the VISCA-over-IP framer.
// No dependencies; every other file uses this package by scoped names.
`default_nettype none
package ptzf_pkg;

   // Command codes of an input transaction
   typedef enum logic [1:0] {
      CMD_CONTROL = 2'd0,
      CMD_DETACH  = 2'd1,
      CMD_RECALL  = 2'd2,
      CMD_SAVE    = 2'd3
   } cmd_type;

   // Fixed protocol bytes
   localparam logic [7:0] BYTE_ADDR      = 8'h81;
   localparam logic [7:0] BYTE_COMMAND   = 8'h01;
   localparam logic [7:0] BYTE_PANTILT   = 8'h06;
   localparam logic [7:0] BYTE_CAMERA    = 8'h04;
   localparam logic [7:0] BYTE_ZOOM      = 8'h07;
   localparam logic [7:0] BYTE_MEMORY    = 8'h3f;
   localparam logic [7:0] BYTE_EXT       = 8'h7e;
   localparam logic [7:0] BYTE_RECALL_SP = 8'h0b;
   localparam logic [7:0] BYTE_RECALL    = 8'h02;
   localparam logic [7:0] BYTE_SET       = 8'h01;
   localparam logic [7:0] BYTE_TERM      = 8'hff;
   localparam logic [7:0] BYTE_ZOOM_IN   = 8'h20;
   localparam logic [7:0] BYTE_ZOOM_OUT  = 8'h30;
   localparam logic [7:0] BYTE_DIR_LEFT  = 8'h01;
   localparam logic [7:0] BYTE_DIR_RIGHT = 8'h02;
   localparam logic [7:0] BYTE_DIR_UP    = 8'h01;
   localparam logic [7:0] BYTE_DIR_DOWN  = 8'h02;
   localparam logic [7:0] BYTE_DIR_STOP  = 8'h03;
   localparam logic [7:0] BYTE_HDR0      = 8'h01;
   localparam logic [7:0] BYTE_HDR1      = 8'h00;
   localparam logic [7:0] STICK_CENTER   = 8'd127;
   localparam logic [3:0] PRESET_SPD_MAX = 4'd8;

   localparam int PAYLOAD_MAX = 9;
   localparam int HEADER_LEN  = 8;
   localparam int JOB_DEPTH   = 2;

   localparam logic [3:0] LEN_PANTILT = 4'd9;
   localparam logic [3:0] LEN_ZOOM    = 4'd6;
   localparam logic [3:0] LEN_PRESET  = 4'd7;
   localparam logic [3:0] LEN_SPEED   = 4'd8;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] pan_stick;
      logic [7:0] tilt_stick;
      logic [7:0] zoom_stick;
      logic [7:0] stick_speed;
      logic [5:0] preset_number;
      logic [3:0] recall_speed;
   } req_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       packet_end;
      logic       item_end;
   } rsp_type;

   // One packet as the back end sends it: payload length and payload bytes
   typedef struct packed {
      logic [3:0]                        len;
      logic [0:PAYLOAD_MAX-1][7:0]       payload;
   } packet_type;

   // One classified transaction: one or two packets
   typedef struct packed {
      logic                  two;
      logic [0:1]            unused_pad;
      packet_type [0:1]      pkt;
   } job_type;

   // Distance of a stick from center, limited to 127
   function automatic logic [6:0] stick_dev(logic [7:0] v);
      logic [7:0] d;
      d = (v > STICK_CENTER) ? (v - STICK_CENTER) : (STICK_CENTER - v);
      return (d > 8'd127) ? 7'd127 : d[6:0];
   endfunction

   // d * 31 / 127, using 127 = 128 - 1 and one correction step
   function automatic logic [4:0] scale31_127(logic [6:0] d);
      logic [11:0] x;
      logic [4:0]  q;
      logic [7:0]  r;
      x = {d, 5'b0} - {5'b0, d};
      q = x[11:7];
      r = {1'b0, x[6:0]} + {3'b0, q};
      return (r >= 8'd127) ? (q + 5'd1) : q;
   endfunction

   // k * 31 / 255, using 255 = 256 - 1 and one correction step
   function automatic logic [4:0] scale31_255(logic [7:0] k);
      logic [12:0] x;
      logic [4:0]  q;
      logic [8:0]  r;
      x = {k, 5'b0} - {5'b0, k};
      q = x[12:8];
      r = {1'b0, x[7:0]} + {4'b0, q};
      return (r >= 9'd255) ? (q + 5'd1) : q;
   endfunction

   // d * 7 / 127 for the zoom speed
   function automatic logic [2:0] scale7_127(logic [6:0] d);
      logic [9:0] x;
      logic [2:0] q;
      logic [7:0] r;
      x = {d, 3'b0} - {3'b0, d};
      q = x[9:7];
      r = {1'b0, x[6:0]} + {5'b0, q};
      return (r >= 8'd127) ? (q + 3'd1) : q;
   endfunction

endpackage
`default_nettype wire

// ===== sv/ptzf_front.sv =====
// Front end: accepts command transactions, tracks last stick values and builds
// packet payloads for the job queue. Depends on ptzf_pkg.
`default_nettype none
module ptzf_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire ptzf_pkg::req_type req_data,
   input  wire logic             q_full,
   output      logic             req_full,
   output      logic             q_push,
   output      ptzf_pkg::job_type q_data
);

   logic [7:0] last_pan_ff,  last_pan_in;
   logic [7:0] last_tilt_ff, last_tilt_in;
   logic [7:0] last_zoom_ff, last_zoom_in;

   logic       accept;
   logic       pt_chg, z_chg;
   logic [5:0] lim, ps_raw, ts_raw, ps, ts;
   logic       right, up;
   logic [7:0] d1, d2, zcode;
   logic [6:0] zdev;
   logic [3:0] pspd;
   logic [7:0] ss;
   logic [7:0] pnum;
   ptzf_pkg::packet_type pt_pkt, pt_stop_pkt, z_pkt, z_stop_pkt;
   ptzf_pkg::packet_type rec_pkt, set_pkt, spd_pkt;
   ptzf_pkg::job_type    job;
   logic       has_job;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // Compare sticks with stored values and scale speeds
   always_comb begin
      pt_chg = (req_data.pan_stick != last_pan_ff) || (req_data.tilt_stick != last_tilt_ff);
      z_chg  = (req_data.zoom_stick != last_zoom_ff);
      lim    = {1'b0, ptzf_pkg::scale31_255(req_data.stick_speed)} + 6'd1;
      ps_raw = {1'b0, ptzf_pkg::scale31_127(ptzf_pkg::stick_dev(req_data.pan_stick))} + 6'd1;
      ts_raw = {1'b0, ptzf_pkg::scale31_127(ptzf_pkg::stick_dev(req_data.tilt_stick))} + 6'd1;
      ps     = (ps_raw > lim) ? lim : ps_raw;
      ts     = (ts_raw > lim) ? lim : ts_raw;
      right  = req_data.pan_stick > ptzf_pkg::STICK_CENTER;
      up     = req_data.tilt_stick < ptzf_pkg::STICK_CENTER;
   end

   // Pick direction codes
   always_comb begin
      priority if (ps > 6'd1 && ts > 6'd1) begin
         d1 = right ? ptzf_pkg::BYTE_DIR_RIGHT : ptzf_pkg::BYTE_DIR_LEFT;
         d2 = up ? ptzf_pkg::BYTE_DIR_UP : ptzf_pkg::BYTE_DIR_DOWN;
      end else if (ts > 6'd1) begin
         d1 = ptzf_pkg::BYTE_DIR_STOP;
         d2 = up ? ptzf_pkg::BYTE_DIR_UP : ptzf_pkg::BYTE_DIR_DOWN;
      end else if (ps > 6'd1) begin
         d1 = right ? ptzf_pkg::BYTE_DIR_RIGHT : ptzf_pkg::BYTE_DIR_LEFT;
         d2 = ptzf_pkg::BYTE_DIR_STOP;
      end else begin
         d1 = ptzf_pkg::BYTE_DIR_STOP;
         d2 = ptzf_pkg::BYTE_DIR_STOP;
      end
   end

   // Zoom code and preset save speed
   always_comb begin
      zdev = ptzf_pkg::stick_dev(req_data.zoom_stick);
      if (req_data.zoom_stick == ptzf_pkg::STICK_CENTER) begin
         zcode = 8'h00;
      end else begin
         zcode = ((req_data.zoom_stick < ptzf_pkg::STICK_CENTER) ? ptzf_pkg::BYTE_ZOOM_IN
                                                                 : ptzf_pkg::BYTE_ZOOM_OUT)
                 | {5'b0, ptzf_pkg::scale7_127(zdev)};
      end
      pspd = (req_data.recall_speed > ptzf_pkg::PRESET_SPD_MAX) ? ptzf_pkg::PRESET_SPD_MAX
                                                                : req_data.recall_speed;
      // pspd * 31 / 8 + 1
      ss   = 8'(({pspd, 5'b0} - {5'b0, pspd}) >> 3) + 8'd1;
      pnum = {2'b0, req_data.preset_number};
   end

   // Assemble the packet payloads
   always_comb begin
      pt_pkt      = '0;
      pt_pkt.len  = ptzf_pkg::LEN_PANTILT;
      pt_pkt.payload = {ptzf_pkg::BYTE_ADDR, ptzf_pkg::BYTE_COMMAND, ptzf_pkg::BYTE_PANTILT,
                        ptzf_pkg::BYTE_COMMAND, {2'b0, ps}, {2'b0, ts}, d1, d2,
                        ptzf_pkg::BYTE_TERM};
      pt_stop_pkt = pt_pkt;
      pt_stop_pkt.payload = {ptzf_pkg::BYTE_ADDR, ptzf_pkg::BYTE_COMMAND,
                             ptzf_pkg::BYTE_PANTILT, ptzf_pkg::BYTE_COMMAND, 8'h01, 8'h01,
                             ptzf_pkg::BYTE_DIR_STOP, ptzf_pkg::BYTE_DIR_STOP,
                             ptzf_pkg::BYTE_TERM};
      z_pkt       = '0;
      z_pkt.len   = ptzf_pkg::LEN_ZOOM;
      z_pkt.payload = {ptzf_pkg::BYTE_ADDR, ptzf_pkg::BYTE_COMMAND, ptzf_pkg::BYTE_CAMERA,
                       ptzf_pkg::BYTE_ZOOM, zcode, ptzf_pkg::BYTE_TERM, 8'h00, 8'h00, 8'h00};
      z_stop_pkt  = z_pkt;
      z_stop_pkt.payload[4] = 8'h00;
      rec_pkt     = '0;
      rec_pkt.len = ptzf_pkg::LEN_PRESET;
      rec_pkt.payload = {ptzf_pkg::BYTE_ADDR, ptzf_pkg::BYTE_COMMAND, ptzf_pkg::BYTE_CAMERA,
                         ptzf_pkg::BYTE_MEMORY, ptzf_pkg::BYTE_RECALL, pnum,
                         ptzf_pkg::BYTE_TERM, 8'h00, 8'h00};
      set_pkt     = rec_pkt;
      set_pkt.payload[4] = ptzf_pkg::BYTE_SET;
      spd_pkt     = '0;
      spd_pkt.len = ptzf_pkg::LEN_SPEED;
      spd_pkt.payload = {ptzf_pkg::BYTE_ADDR, ptzf_pkg::BYTE_COMMAND, ptzf_pkg::BYTE_EXT,
                         ptzf_pkg::BYTE_COMMAND, ptzf_pkg::BYTE_RECALL_SP, pnum, ss,
                         ptzf_pkg::BYTE_TERM, 8'h00};
   end

   // Classify the command into a job
   always_comb begin
      job     = '0;
      has_job = 1'b1;
      unique case (ptzf_pkg::cmd_type'(req_data.cmd))
         ptzf_pkg::CMD_CONTROL: begin
            has_job = pt_chg || z_chg;
            job.two = pt_chg && z_chg;
            job.pkt[0] = pt_chg ? pt_pkt : z_pkt;
            job.pkt[1] = z_pkt;
         end
         ptzf_pkg::CMD_DETACH: begin
            job.two    = 1'b1;
            job.pkt[0] = pt_stop_pkt;
            job.pkt[1] = z_stop_pkt;
         end
         ptzf_pkg::CMD_RECALL: begin
            job.pkt[0] = rec_pkt;
            job.pkt[1] = rec_pkt;
         end
         ptzf_pkg::CMD_SAVE: begin
            job.two    = 1'b1;
            job.pkt[0] = set_pkt;
            job.pkt[1] = spd_pkt;
         end
         default: begin
            has_job = 1'b0;
         end
      endcase
   end

   assign q_push = accept && has_job;
   assign q_data = job;

   // Update stored stick values on an accepted control update
   always_comb begin
      last_pan_in  = last_pan_ff;
      last_tilt_in = last_tilt_ff;
      last_zoom_in = last_zoom_ff;
      if (accept && req_data.cmd == ptzf_pkg::CMD_CONTROL) begin
         last_pan_in  = req_data.pan_stick;
         last_tilt_in = req_data.tilt_stick;
         last_zoom_in = req_data.zoom_stick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pan_ff  <= '0;
         last_tilt_ff <= '0;
         last_zoom_ff <= '0;
      end else begin
         last_pan_ff  <= last_pan_in;
         last_tilt_ff <= last_tilt_in;
         last_zoom_ff <= last_zoom_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/ptzf_job_fifo.sv =====
// Short job queue between the front end and the serializer.
// Depends on ptzf_pkg for the job type and depth.
`default_nettype none
module ptzf_job_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ptzf_pkg::job_type push_data,
   output      logic              full,
   input  wire logic              pop,
   output      logic              empty,
   output      ptzf_pkg::job_type pop_data
);

   localparam int PtrW = $clog2(ptzf_pkg::JOB_DEPTH);

   ptzf_pkg::job_type entry_ff [ptzf_pkg::JOB_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]   count_ff,  count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == (PtrW+1)'(ptzf_pkg::JOB_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? (wr_ptr_ff + PtrW'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop ? (rd_ptr_ff + PtrW'(1)) : rd_ptr_ff;
      count_in  = count_ff + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== sv/ptzf_serializer.sv =====
// Back end: takes jobs from the queue, adds headers with the sequence number and sends one
// byte per cycle through an output register while rsp_pop takes each byte. Depends on ptzf_pkg.
`default_nettype none
module ptzf_serializer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire ptzf_pkg::job_type q_data,
   output      logic              q_pop,
   output      logic              rsp_empty,
   input  wire logic              rsp_pop,
   output      ptzf_pkg::rsp_type rsp_data
);

   ptzf_pkg::job_type job_ff, job_in;
   logic              busy_ff, busy_in;
   logic              pkt_sel_ff, pkt_sel_in;
   logic [4:0]        idx_ff, idx_in;
   logic [31:0]       seq_ff, seq_in;
   logic              out_valid_ff, out_valid_in;
   ptzf_pkg::rsp_type out_ff, out_in;

   ptzf_pkg::packet_type cur;
   logic       advance, emit, last_byte, item_last;
   logic [3:0] pidx;
   logic [7:0] pbyte, hbyte;

   assign advance   = !out_valid_ff || rsp_pop;
   assign emit      = busy_ff && advance;
   assign q_pop     = !busy_ff && !q_empty;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // Select the current byte of header or payload
   always_comb begin
      cur       = job_ff.pkt[pkt_sel_ff];
      last_byte = (idx_ff == ({1'b0, cur.len} + 5'd7));
      item_last = last_byte && (pkt_sel_ff || !job_ff.two);
      pidx      = 4'(idx_ff - 5'd8);
      pbyte     = 8'h00;
      for (int i = 0; i < ptzf_pkg::PAYLOAD_MAX; i++) begin
         if (pidx == 4'(i)) begin
            pbyte = cur.payload[i];
         end
      end
      unique case (idx_ff[2:0])
         3'd0:    hbyte = ptzf_pkg::BYTE_HDR0;
         3'd1:    hbyte = ptzf_pkg::BYTE_HDR1;
         3'd2:    hbyte = 8'h00;
         3'd3:    hbyte = {4'b0, cur.len};
         3'd4:    hbyte = seq_ff[31:24];
         3'd5:    hbyte = seq_ff[23:16];
         3'd6:    hbyte = seq_ff[15:8];
         default: hbyte = seq_ff[7:0];
      endcase
   end

   // Load jobs, step through bytes, bump the sequence number per packet
   always_comb begin
      job_in     = job_ff;
      busy_in    = busy_ff;
      pkt_sel_in = pkt_sel_ff;
      idx_in     = idx_ff;
      seq_in     = seq_ff;
      if (q_pop) begin
         job_in     = q_data;
         busy_in    = 1'b1;
         pkt_sel_in = 1'b0;
         idx_in     = '0;
      end else if (emit) begin
         idx_in = idx_ff + 5'd1;
         if (last_byte) begin
            seq_in = seq_ff + 32'd1;
            idx_in = '0;
            if (item_last) begin
               busy_in = 1'b0;
            end else begin
               pkt_sel_in = 1'b1;
            end
         end
      end
   end

   // Output register
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (emit) begin
         out_valid_in       = 1'b1;
         out_in.packet_byte = (idx_ff < 5'(ptzf_pkg::HEADER_LEN)) ? hbyte : pbyte;
         out_in.packet_end  = last_byte;
         out_in.item_end    = item_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pkt_sel_ff   <= 1'b0;
         idx_ff       <= '0;
         seq_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pkt_sel_ff   <= pkt_sel_in;
         idx_ff       <= idx_in;
         seq_ff       <= seq_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      out_ff <= out_in;
   end

endmodule
`default_nettype wire

// ===== sv/ptz_visca_ip_command_framer.sv =====
// VISCA-over-IP command framer top level: front end, job queue, serializer.
// With the queue and serializer idle, an accepted command passes the job queue entry,
// the serializer job register and its output register before its first byte shows.
// Throughput: one byte per cycle while rsp_pop takes each byte; a command takes 8 + payload
// bytes per packet, and the serializer loads a job from the two-entry queue only when idle.
// Reset (synchronous, active high) clears last stick values, sequence number and queues.
// Depends on ptzf_pkg, ptzf_front, ptzf_job_fifo and ptzf_serializer.
`default_nettype none
module ptz_visca_ip_command_framer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output      logic              req_full,
   input  wire ptzf_pkg::req_type req_data,
   output      logic              rsp_empty,
   input  wire logic              rsp_pop,
   output      ptzf_pkg::rsp_type rsp_data
);

   logic              q_push, q_full, q_pop, q_empty;
   ptzf_pkg::job_type q_wdata, q_rdata;

   // Classify commands
   ptzf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .req_full (req_full),
      .q_push   (q_push),
      .q_data   (q_wdata)
   );

   // Decouple front and back
   ptzf_job_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_rdata)
   );

   // Serialize packets
   ptzf_serializer u_ser (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
